// ----- rtl/line_pixel_generator_assert.svh -----
// ----------------------------------------------------------------------------
// line_pixel_generator_assert.svh
// Assertion macros of the line pixel generator RTL; empty in synthesis
// ----------------------------------------------------------------------------
`ifndef LINE_PIXEL_GENERATOR_ASSERT_SVH
`define LINE_PIXEL_GENERATOR_ASSERT_SVH

`ifndef SYNTHESIS

// clocked check, off while reset is asserted
`define LPG_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// clocked check that also holds through reset
`define LPG_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define LPG_ASSERT(label, clk, rst_n, prop, msg)
`define LPG_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ----- rtl/lpg_pkg.sv -----
// ----------------------------------------------------------------------------
// lpg_pkg
// Shared types and constants of the line pixel generator
// ----------------------------------------------------------------------------
`default_nettype none

package lpg_pkg;

    // default coordinate width and fixed color width
    localparam int COORD_WIDTH_DEF = 10;
    localparam int COLOR_WIDTH     = 24;
    // decision term carries this many bits beyond the coordinate width
    localparam int DEC_EXTRA       = 4;

    // command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_NEXT  = 1'b1;

    // octant of a line after the endpoint swap (x never falls)
    typedef enum logic [1:0] {
        OCT_SHALLOW_UP   = 2'd0,
        OCT_STEEP_UP     = 2'd1,
        OCT_SHALLOW_DOWN = 2'd2,
        OCT_STEEP_DOWN   = 2'd3
    } octant_t;

    // control from the setup register to the stepper
    typedef struct packed {
        logic    valid;
        logic    start;
        octant_t octant;
    } setup_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/lpg_setup.sv -----
// ----------------------------------------------------------------------------
// lpg_setup
// Input register with line setup: endpoint swap, octant choice, decision terms
// ----------------------------------------------------------------------------
`default_nettype none

module lpg_setup import lpg_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_cmd,
    input  logic [COORD_WIDTH-1:0]        s_start_x,
    input  logic [COORD_WIDTH-1:0]        s_start_y,
    input  logic [COORD_WIDTH-1:0]        s_end_x,
    input  logic [COORD_WIDTH-1:0]        s_end_y,
    input  logic [COLOR_WIDTH-1:0]        s_line_color,
    // to the stepper
    input  logic                          step_ready,
    output setup_ctrl_t                   ctrl,
    output logic [COORD_WIDTH-1:0]        x0,
    output logic [COORD_WIDTH-1:0]        y0,
    output logic [COORD_WIDTH-1:0]        x1,
    output logic [COORD_WIDTH-1:0]        y1,
    output logic [COORD_WIDTH+DEC_EXTRA-1:0] dec_init,
    output logic [COORD_WIDTH+DEC_EXTRA-1:0] inc_diag,
    output logic [COORD_WIDTH+DEC_EXTRA-1:0] inc_axial,
    output logic [COLOR_WIDTH-1:0]        color
);

    localparam int CW = COORD_WIDTH;
    localparam int DW = COORD_WIDTH + DEC_EXTRA;

    logic               valid_reg, valid_next;
    logic               start_reg;
    octant_t            octant_reg, octant_next;
    logic [CW-1:0]      x0_reg, y0_reg, x1_reg, y1_reg;
    logic [CW-1:0]      x0_next, y0_next, x1_next, y1_next;
    logic [DW-1:0]      dec_reg, dec_next;
    logic [DW-1:0]      diag_reg, diag_next;
    logic [DW-1:0]      axial_reg, axial_next;
    logic [COLOR_WIDTH-1:0] color_reg;

    logic               swap;
    logic               falling;
    logic               steep;
    logic [CW-1:0]      dx, ady, major, minor;
    logic [DW-1:0]      minor2, major1, major2;
    logic               take;

    assign take    = s_valid && s_ready;
    assign s_ready = !valid_reg || step_ready;

    // order endpoints so that x rises, then pick octant and decision terms
    always_comb begin
        swap    = s_start_x > s_end_x;
        x0_next = swap ? s_end_x   : s_start_x;
        y0_next = swap ? s_end_y   : s_start_y;
        x1_next = swap ? s_start_x : s_end_x;
        y1_next = swap ? s_start_y : s_end_y;
        dx      = x1_next - x0_next;
        falling = y1_next < y0_next;
        ady     = falling ? (y0_next - y1_next) : (y1_next - y0_next);
        steep   = ady > dx;
        major   = steep ? ady : dx;
        minor   = steep ? dx  : ady;
        case ({falling, steep})
            2'b00:   octant_next = OCT_SHALLOW_UP;
            2'b01:   octant_next = OCT_STEEP_UP;
            2'b10:   octant_next = OCT_SHALLOW_DOWN;
            2'b11:   octant_next = OCT_STEEP_DOWN;
            default: octant_next = OCT_SHALLOW_UP;
        endcase
        minor2     = {{(DEC_EXTRA-1){1'b0}}, minor, 1'b0};
        major1     = {{DEC_EXTRA{1'b0}}, major};
        major2     = {{(DEC_EXTRA-1){1'b0}}, major, 1'b0};
        dec_next   = minor2 - major1;
        diag_next  = minor2 - major2;
        axial_next = minor2;
    end

    // valid flag of the input register
    always_comb begin
        if (take) begin
            valid_next = 1'b1;
        end else if (step_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload of the input register
    always_ff @(posedge aclk) begin
        if (take) begin
            start_reg  <= (s_cmd == CMD_START);
            octant_reg <= octant_next;
            x0_reg     <= x0_next;
            y0_reg     <= y0_next;
            x1_reg     <= x1_next;
            y1_reg     <= y1_next;
            dec_reg    <= dec_next;
            diag_reg   <= diag_next;
            axial_reg  <= axial_next;
            color_reg  <= s_line_color;
        end
    end

    assign ctrl.valid  = valid_reg;
    assign ctrl.start  = start_reg;
    assign ctrl.octant = octant_reg;
    assign x0          = x0_reg;
    assign y0          = y0_reg;
    assign x1          = x1_reg;
    assign y1          = y1_reg;
    assign dec_init    = dec_reg;
    assign inc_diag    = diag_reg;
    assign inc_axial   = axial_reg;
    assign color       = color_reg;

endmodule

`default_nettype wire

// ----- rtl/lpg_step.sv -----
// ----------------------------------------------------------------------------
// lpg_step
// Line state and one midpoint step per transaction, into the result register
// ----------------------------------------------------------------------------
`default_nettype none

`include "line_pixel_generator_assert.svh"

module lpg_step import lpg_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // from the setup register
    input  setup_ctrl_t                   ctrl,
    input  logic [COORD_WIDTH-1:0]        x0,
    input  logic [COORD_WIDTH-1:0]        y0,
    input  logic [COORD_WIDTH-1:0]        x1,
    input  logic [COORD_WIDTH-1:0]        y1,
    input  logic [COORD_WIDTH+DEC_EXTRA-1:0] dec_init,
    input  logic [COORD_WIDTH+DEC_EXTRA-1:0] inc_diag,
    input  logic [COORD_WIDTH+DEC_EXTRA-1:0] inc_axial,
    input  logic [COLOR_WIDTH-1:0]        color,
    output logic                          step_ready,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [COORD_WIDTH-1:0]        m_pixel_x,
    output logic [COORD_WIDTH-1:0]        m_pixel_y,
    output logic [COLOR_WIDTH-1:0]        m_pixel_color,
    output logic                          m_pixel_valid,
    output logic                          m_last_pixel
);

    localparam int CW = COORD_WIDTH;
    localparam int DW = COORD_WIDTH + DEC_EXTRA;
    localparam logic [CW-1:0] ONE = {{(CW-1){1'b0}}, 1'b1};

    // line state
    logic               active_reg, active_next;
    octant_t            octant_reg, octant_next;
    logic [CW-1:0]      cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic [CW-1:0]      tgt_x_reg, tgt_x_next, tgt_y_reg, tgt_y_next;
    logic [DW-1:0]      dec_reg, dec_next;
    logic [DW-1:0]      diag_reg, diag_next, axial_reg, axial_next;
    logic [COLOR_WIDTH-1:0] color_reg, color_next;

    // result register
    logic               m_valid_reg, m_valid_next;
    logic [CW-1:0]      px_reg, px_next, py_reg, py_next;
    logic [COLOR_WIDTH-1:0] pcolor_reg, pcolor_next;
    logic               pvalid_reg, pvalid_next;
    logic               plast_reg, plast_next;

    logic               fire;
    logic               eff_active, eff_last;
    logic               steep, falling, dec_pos;
    logic               step_x, step_y;
    logic [CW-1:0]      x_adv, y_adv;
    logic [DW-1:0]      dec_adv;

    assign step_ready = !m_valid_reg || m_ready;
    assign fire       = ctrl.valid && step_ready;

    // a start transaction takes its values from setup, a next one from state
    always_comb begin
        octant_next = ctrl.start ? ctrl.octant : octant_reg;
        cur_x_next  = ctrl.start ? x0        : cur_x_reg;
        cur_y_next  = ctrl.start ? y0        : cur_y_reg;
        tgt_x_next  = ctrl.start ? x1        : tgt_x_reg;
        tgt_y_next  = ctrl.start ? y1        : tgt_y_reg;
        dec_next    = ctrl.start ? dec_init  : dec_reg;
        diag_next   = ctrl.start ? inc_diag  : diag_reg;
        axial_next  = ctrl.start ? inc_axial : axial_reg;
        color_next  = ctrl.start ? color     : color_reg;
        eff_active  = ctrl.start || active_reg;
    end

    // endpoint test and one midpoint step
    always_comb begin
        steep    = (octant_next == OCT_STEEP_UP) || (octant_next == OCT_STEEP_DOWN);
        falling  = (octant_next == OCT_SHALLOW_DOWN) || (octant_next == OCT_STEEP_DOWN);
        eff_last = steep ? (cur_y_next == tgt_y_next) : (cur_x_next == tgt_x_next);
        dec_pos  = !dec_next[DW-1] && (dec_next != '0);
        step_x   = !steep || dec_pos;
        step_y   = steep || dec_pos;
        x_adv    = step_x ? (cur_x_next + ONE) : cur_x_next;
        if (!step_y) begin
            y_adv = cur_y_next;
        end else if (falling) begin
            y_adv = cur_y_next - ONE;
        end else begin
            y_adv = cur_y_next + ONE;
        end
        dec_adv  = dec_next + (dec_pos ? diag_next : axial_next);
    end

    // active flag and result register control
    always_comb begin
        active_next  = active_reg;
        m_valid_next = m_valid_reg;
        if (fire) begin
            active_next  = eff_active && !eff_last;
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // result payload; a next transaction with no line gives all zeros
    always_comb begin
        pvalid_next = eff_active;
        plast_next  = eff_active && eff_last;
        px_next     = eff_active ? cur_x_next : '0;
        py_next     = eff_active ? cur_y_next : '0;
        pcolor_next = eff_active ? color_next : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            active_reg  <= active_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // line state update; the position stays put on the endpoint pixel
    always_ff @(posedge aclk) begin
        if (fire && eff_active) begin
            octant_reg <= octant_next;
            tgt_x_reg  <= tgt_x_next;
            tgt_y_reg  <= tgt_y_next;
            diag_reg   <= diag_next;
            axial_reg  <= axial_next;
            color_reg  <= color_next;
            cur_x_reg  <= eff_last ? cur_x_next : x_adv;
            cur_y_reg  <= eff_last ? cur_y_next : y_adv;
            dec_reg    <= eff_last ? dec_next   : dec_adv;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            px_reg     <= px_next;
            py_reg     <= py_next;
            pcolor_reg <= pcolor_next;
            pvalid_reg <= pvalid_next;
            plast_reg  <= plast_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_pixel_x     = px_reg;
    assign m_pixel_y     = py_reg;
    assign m_pixel_color = pcolor_reg;
    assign m_pixel_valid = pvalid_reg;
    assign m_last_pixel  = plast_reg;

    // assertions
    `LPG_ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> !m_valid_reg && !active_reg, "result or line active after reset")
    `LPG_ASSERT(a_idle_zero, aclk, aresetn, m_valid_reg && !pvalid_reg |-> px_reg == '0 && py_reg == '0 && pcolor_reg == '0 && !plast_reg, "idle result not all zero")
    `LPG_ASSERT(a_last_ends_line, aclk, aresetn, fire && eff_active && eff_last |=> !active_reg && plast_reg, "line still active after its last pixel")
    `LPG_ASSERT(a_step_moves, aclk, aresetn, fire && eff_active && !eff_last |=> active_reg && (cur_x_reg != $past(cur_x_next) || cur_y_reg != $past(cur_y_next)), "step did not move the position")

endmodule

`default_nettype wire

// ----- rtl/line_pixel_generator.sv -----
// ----------------------------------------------------------------------------
// line_pixel_generator
// Midpoint line rasterizer: one start or next transaction in, one result out
// ----------------------------------------------------------------------------
//  channel  | handshake         | payload
//  ---------+-------------------+---------------------------------------------
//  input    | s_valid / s_ready | s_cmd, s_start_x/y, s_end_x/y, s_line_color
//  result   | m_valid / m_ready | m_pixel_x/y, m_pixel_color, m_pixel_valid,
//           |                   | m_last_pixel
//
//  one transaction per clock while the result channel is not stalled; an
//  accepted transaction is held in the setup register and then in the
//  stepper's result register, whose valid flag drives m_valid
//  the loop through the line state register (decision compare and add) sets
//  the rate: each next transaction uses the state the prior one left
//  reset clears both valid flags and the line active flag
//  a stalled result holds the result register; the setup register takes one
//  more transaction only if it is empty, after which s_ready drops
// ----------------------------------------------------------------------------
`default_nettype none

module line_pixel_generator import lpg_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // input channel
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_cmd,
    input  logic [COORD_WIDTH-1:0] s_start_x,
    input  logic [COORD_WIDTH-1:0] s_start_y,
    input  logic [COORD_WIDTH-1:0] s_end_x,
    input  logic [COORD_WIDTH-1:0] s_end_y,
    input  logic [COLOR_WIDTH-1:0] s_line_color,
    // result channel
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [COORD_WIDTH-1:0] m_pixel_x,
    output logic [COORD_WIDTH-1:0] m_pixel_y,
    output logic [COLOR_WIDTH-1:0] m_pixel_color,
    output logic                   m_pixel_valid,
    output logic                   m_last_pixel
);

    localparam int DW = COORD_WIDTH + DEC_EXTRA;

    setup_ctrl_t            ctrl;
    logic                   step_ready;
    logic [COORD_WIDTH-1:0] x0, y0, x1, y1;
    logic [DW-1:0]          dec_init, inc_diag, inc_axial;
    logic [COLOR_WIDTH-1:0] color;

    // input register with endpoint ordering and octant setup
    lpg_setup #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_setup (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_start_x    (s_start_x),
        .s_start_y    (s_start_y),
        .s_end_x      (s_end_x),
        .s_end_y      (s_end_y),
        .s_line_color (s_line_color),
        .step_ready   (step_ready),
        .ctrl         (ctrl),
        .x0           (x0),
        .y0           (y0),
        .x1           (x1),
        .y1           (y1),
        .dec_init     (dec_init),
        .inc_diag     (inc_diag),
        .inc_axial    (inc_axial),
        .color        (color)
    );

    // line state, midpoint step and result register
    lpg_step #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_step (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctrl          (ctrl),
        .x0            (x0),
        .y0            (y0),
        .x1            (x1),
        .y1            (y1),
        .dec_init      (dec_init),
        .inc_diag      (inc_diag),
        .inc_axial     (inc_axial),
        .color         (color),
        .step_ready    (step_ready),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_x     (m_pixel_x),
        .m_pixel_y     (m_pixel_y),
        .m_pixel_color (m_pixel_color),
        .m_pixel_valid (m_pixel_valid),
        .m_last_pixel  (m_last_pixel)
    );

endmodule

`default_nettype wire
